// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that fall away in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WOTN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("wotn assertion failed");
`define WOTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wotn assertion failed");
`else
`define WOTN_ASSERT(label, clk, rst, prop)
`define WOTN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/wotn_pkg.sv =====
// ---------------------------------------------------------------------------
// Window overlap package
// Widths, defaults, the name table entry type and a saturating adder.
// ---------------------------------------------------------------------------
package wotn_pkg;

  localparam int TOP_COUNT_DEF  = 8;
  localparam int NAME_SLOTS_DEF = 64;

  localparam int TS_W    = 48;
  localparam int LEN_W   = 40;
  localparam int NAME_W  = 32;
  localparam int DEPTH_W = 8;
  localparam int TOT_W   = 56;
  localparam int Q_W     = 32;
  localparam int RANK_W  = 3;
  localparam int CNT_W   = 4;

  typedef struct packed {
    logic [NAME_W-1:0] key;
    logic [TOT_W-1:0]  total;
  } entry_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

// ===== hdl/wotn_table.sv =====
// ---------------------------------------------------------------------------
// Name table
// Synchronous memory of name keys and accumulated totals, one read port and
// one write port, read data registered.
// ---------------------------------------------------------------------------
module wotn_table import wotn_pkg::*; #(
  parameter int NAME_SLOTS = NAME_SLOTS_DEF,
  parameter int AW = $clog2(NAME_SLOTS)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [NAME_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/wotn_div.sv =====
// ---------------------------------------------------------------------------
// Concurrency divider
// Restoring divider, one quotient bit a cycle, giving the overlap sum over
// the window length as saturated unsigned Q16.16.
// ---------------------------------------------------------------------------
module wotn_div import wotn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOT_W-1:0] sum,
  input  logic [LEN_W-1:0] len,
  output logic             busy,
  output logic [Q_W-1:0]   result
);

  localparam int DVD_W = TOT_W + 16;
  localparam int CNT_B = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [LEN_W-1:0] dsr;
  logic [LEN_W-1:0] rem;
  logic [CNT_B-1:0] cnt;
  logic [LEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_B'(DVD_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {sum, 16'b0};
      dsr <= (len == '0) ? LEN_W'(1) : len;
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? LEN_W'(trial - {1'b0, dsr}) : trial[LEN_W-1:0];
      cnt <= cnt + CNT_B'(1);
    end
  end

  assign result = (|quo[DVD_W-1:Q_W]) ? {Q_W{1'b1}} : quo[Q_W-1:0];

endmodule

// ===== hdl/window_overlap_top_names_core.sv =====
// ---------------------------------------------------------------------------
// Window overlap top names core
// Accumulates per-name overlap with a time window and reports the top names.
// ---------------------------------------------------------------------------
// An item that does not count is taken in S_IDLE; a counting item that overlaps
// the window passes S_OV, then S_RD and S_CMP per table entry compared, and one
// more S_RD when its name is new. The last item of a window runs the divider in
// S_DIV; each ranked result scans all used entries before it is offered.
// Reset is synchronous and resets the control state and window registers.
`include "assert_macros.svh"
module window_overlap_top_names_core import wotn_pkg::*; #(
  parameter int TOP_COUNT  = TOP_COUNT_DEF,
  parameter int NAME_SLOTS = NAME_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [0:0]         wr_index,
  input  logic [TS_W-1:0]    wr_data,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  logic [TS_W-1:0]    event_start,
  input  logic [LEN_W-1:0]   event_length,
  input  logic [NAME_W-1:0]  name_id,
  input  logic [DEPTH_W-1:0] nesting_depth,
  input  logic               on_thread_track,
  input  logic               item_valid,
  input  logic               end_of_window,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [Q_W-1:0]     concurrency_q16,
  output logic [RANK_W-1:0]  rank,
  output logic [NAME_W-1:0]  top_name,
  output logic               name_present,
  output logic [CNT_W-1:0]   dominant_count,
  output logic               table_overflow,
  output logic               last_result
);

  localparam int AW   = $clog2(NAME_SLOTS);
  localparam int NU_W = $clog2(NAME_SLOTS + 1);
  localparam int RC_W = $clog2(TOP_COUNT + 1);

  localparam logic [0:0] REG_START = 1'd0;
  localparam logic [0:0] REG_LEN   = 1'd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OV   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_RRD  = 3'd5;
  localparam logic [2:0] S_RCMP = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state;
  logic [TS_W-1:0]   window_start;
  logic [LEN_W-1:0]  window_length;
  logic [NU_W-1:0]   names_used;
  logic [TOT_W-1:0]  overlap_sum;
  logic              overflow_seen;

  logic [TS_W:0]     ev_end;
  logic [TS_W:0]     win_end;
  logic [TS_W-1:0]   lo;
  logic [NAME_W-1:0] name_r;
  logic              last_r;
  logic [LEN_W:0]    ov;
  logic [NU_W-1:0]   idx;

  logic [RC_W-1:0]   cnt;
  logic [RC_W-1:0]   r;
  logic              have_prev;
  logic [TOT_W-1:0]  prev_total;
  logic [NU_W-1:0]   prev_idx;
  logic              have_best;
  logic [TOT_W-1:0]  best_total;
  logic [NAME_W-1:0] best_key;
  logic [NU_W-1:0]   best_idx;

  logic              div_started;
  logic              div_start;
  logic              div_busy;
  logic [Q_W-1:0]    div_result;

  logic              rd_en;
  logic              wr_en_t;
  logic [AW-1:0]     wr_addr;
  entry_t            rd_data;
  entry_t            wr_data_t;

  logic [TS_W:0]     hi;
  logic              counts;
  logic              cand;
  logic [RC_W-1:0]   cnt_now;

  assign ev_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign div_start = (state == S_DIV) && !div_started;
  assign hi        = (ev_end < win_end) ? ev_end : win_end;
  assign counts    = item_valid && on_thread_track && nesting_depth == '0;
  assign cand      = !have_prev || rd_data.total < prev_total ||
                     (rd_data.total == prev_total && idx > prev_idx);
  assign cnt_now   = (32'(names_used) < TOP_COUNT) ? RC_W'(names_used)
                                                   : RC_W'(TOP_COUNT);

  always_comb begin
    rd_en     = (state == S_RD || state == S_RRD) && idx != names_used;
    wr_en_t   = 1'b0;
    wr_addr   = idx[AW-1:0];
    wr_data_t = '{key: name_r, total: TOT_W'(ov)};
    if (state == S_RD && idx == names_used && 32'(names_used) < NAME_SLOTS) begin
      wr_en_t = 1'b1;
    end else if (state == S_CMP && rd_data.key == name_r) begin
      wr_en_t   = 1'b1;
      wr_data_t = '{key: name_r, total: sat_add(rd_data.total, TOT_W'(ov))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_length <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START: window_start  <= wr_data;
        REG_LEN:   window_length <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      names_used    <= '0;
      overlap_sum   <= '0;
      overflow_seen <= 1'b0;
      div_started   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ev_valid) begin
            ev_end  <= {1'b0, event_start} + (TS_W + 1)'(event_length);
            win_end <= {1'b0, window_start} + (TS_W + 1)'(window_length);
            lo      <= (event_start > window_start) ? event_start : window_start;
            name_r  <= name_id;
            last_r  <= end_of_window;
            if (counts) begin
              state <= S_OV;
            end else if (end_of_window) begin
              state <= S_DIV;
            end
          end
        end
        S_OV: begin
          idx <= '0;
          if (hi > {1'b0, lo}) begin
            ov          <= (LEN_W + 1)'(hi - {1'b0, lo});
            overlap_sum <= sat_add(overlap_sum, TOT_W'(hi - {1'b0, lo}));
            state       <= S_RD;
          end else begin
            state <= last_r ? S_DIV : S_IDLE;
          end
        end
        S_RD: begin
          if (idx == names_used) begin
            if (32'(names_used) < NAME_SLOTS) begin
              names_used <= names_used + NU_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            state <= last_r ? S_DIV : S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data.key == name_r) begin
            state <= last_r ? S_DIV : S_IDLE;
          end else begin
            idx   <= idx + NU_W'(1);
            state <= S_RD;
          end
        end
        S_DIV: begin
          if (!div_started) begin
            div_started <= 1'b1;
          end else if (!div_busy) begin
            div_started     <= 1'b0;
            concurrency_q16 <= div_result;
            cnt             <= cnt_now;
            r               <= '0;
            have_prev       <= 1'b0;
            have_best       <= 1'b0;
            idx             <= '0;
            table_overflow  <= overflow_seen;
            dominant_count  <= CNT_W'(cnt_now);
            if (cnt_now == '0) begin
              rank         <= '0;
              top_name     <= '0;
              name_present <= 1'b0;
              last_result  <= 1'b1;
              state        <= S_OUT;
            end else begin
              state <= S_RRD;
            end
          end
        end
        S_RRD: begin
          if (idx == names_used) begin
            rank         <= RANK_W'(r);
            top_name     <= best_key;
            name_present <= 1'b1;
            last_result  <= (r + RC_W'(1) == cnt);
            state        <= S_OUT;
          end else begin
            state <= S_RCMP;
          end
        end
        S_RCMP: begin
          if (cand && (!have_best || rd_data.total > best_total)) begin
            have_best  <= 1'b1;
            best_total <= rd_data.total;
            best_key   <= rd_data.key;
            best_idx   <= idx;
          end
          idx   <= idx + NU_W'(1);
          state <= S_RRD;
        end
        S_OUT: begin
          if (res_ready) begin
            if (last_result) begin
              names_used    <= '0;
              overlap_sum   <= '0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end else begin
              r          <= r + RC_W'(1);
              have_prev  <= 1'b1;
              prev_total <= best_total;
              prev_idx   <= best_idx;
              have_best  <= 1'b0;
              idx        <= '0;
              state      <= S_RRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wotn_table #(
    .NAME_SLOTS(NAME_SLOTS),
    .AW        (AW)
  ) u_table (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data),
    .wr_en  (wr_en_t),
    .wr_addr(wr_addr),
    .wr_data(wr_data_t)
  );

  wotn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (overlap_sum),
    .len   (window_length),
    .busy  (div_busy),
    .result(div_result)
  );

  `WOTN_ASSERT(a_used_bound, clk, rst, 32'(names_used) <= NAME_SLOTS)
  `WOTN_ASSERT(a_one_side, clk, rst, !(ev_ready && res_valid))
  `WOTN_ASSERT_NEXT(a_clear, clk, rst, res_valid && res_ready && last_result, names_used == '0 && overlap_sum == '0)
  `WOTN_ASSERT_NEXT(a_div_run, clk, rst, div_start, div_busy)

endmodule
